>>> hdl/ltlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ltlb_pkg;

    // Geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 20;
    localparam int LIMIT_W = 5;
    localparam int CAP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // Item function codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

    typedef struct packed {
        logic               func;
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] fill_frame;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
    } out_t;

    // Search token walking down the cell row
    typedef struct packed {
        logic               live;
        logic               found;
        logic [IDX_W-1:0]   found_idx;
        logic [RANK_W-1:0]  found_rank;
        logic [FRAME_W-1:0] found_frame;
        logic [CNT_W-1:0]   count;
        logic               old_ok;
        logic [IDX_W-1:0]   old_idx;
        logic [RANK_W-1:0]  old_rank;
        logic [PAGE_W-1:0]  old_page;
        logic               free_ok;
        logic [IDX_W-1:0]   free_idx;
    } tok_t;

    // Update broadcast to all cells at commit
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               wr_page;
        logic               wr_frame;
        logic               set_valid;
        logic               age_all;
        logic [RANK_W-1:0]  thr;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } upd_t;

endpackage

`default_nettype wire

>>> hdl/ltlb_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ltlb_cell
    import ltlb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W-1:0]  cell_idx,
    input  wire logic [PAGE_W-1:0] item_page,
    input  wire tok_t              tok_in,
    output tok_t                   tok_out,
    input  wire upd_t              upd
);

    logic [PAGE_W-1:0]  page_reg,  page_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg,  rank_next;
    tok_t               tok_reg,   tok_next;
    logic               live_reg;

    // Fold this slot into the passing token
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg)
        begin
            tok_next.count = tok_in.count + CNT_W'(1);
            if (!tok_in.found && page_reg == item_page)
            begin
                tok_next.found       = 1'b1;
                tok_next.found_idx   = cell_idx;
                tok_next.found_rank  = rank_reg;
                tok_next.found_frame = frame_reg;
            end
            if (!tok_in.old_ok || rank_reg > tok_in.old_rank)
            begin
                tok_next.old_ok   = 1'b1;
                tok_next.old_idx  = cell_idx;
                tok_next.old_rank = rank_reg;
                tok_next.old_page = page_reg;
            end
        end
        else if (!tok_in.free_ok)
        begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = cell_idx;
        end
    end

    // Apply commit: write the target slot, age the younger ones
    always_comb
    begin
        page_next  = page_reg;
        frame_next = frame_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en && upd.idx == cell_idx)
        begin
            if (upd.wr_page)
                page_next = upd.page;
            if (upd.wr_frame)
                frame_next = upd.frame;
            if (upd.set_valid)
                valid_next = 1'b1;
            rank_next = '0;
        end
        else if (upd.en && valid_reg && (upd.age_all || rank_reg < upd.thr))
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    // Control state and token live bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            live_reg  <= tok_in.live;
        end
    end

    // Slot payload and token payload
    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        frame_reg <= frame_next;
        if (tok_in.live)
            tok_reg <= tok_next;
    end

    // Hand the token to the next cell
    always_comb
    begin
        tok_out      = tok_reg;
        tok_out.live = live_reg;
    end

endmodule

`default_nettype wire

>>> hdl/lru_tlb.sv
// Fully associative translation buffer with least-recently-used replacement,
// built as a row of ENTRIES slot cells. An accepted item sends a search token
// down the row one cell per cycle; at the end of the row the outcome (hit,
// free slot or victim) is committed to all cells at once and the result
// is loaded into the output register. A new item is accepted only once the
// previous one has been committed, after its token has walked the whole row.
// The store is empty after reset with no clearing pass. Write entry_limit
// only while the block is idle; 0 acts as 1 and values above ENTRIES act as
// ENTRIES.
`timescale 1ns / 1ps
`default_nettype none

module lru_tlb
    import ltlb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_t                in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_t                    out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg;
    in_t                item_reg;
    logic               start_reg;
    tok_t               fin_reg;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg;

    tok_t               tok_w [ENTRIES+1];
    upd_t               upd;
    out_t               result;
    logic               in_acc;
    logic               out_free;
    logic               commit;
    logic [CAP_W-1:0]   cap;
    logic               full;
    logic [PAGE_W-1:0]  item_page_w;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == ST_COMMIT) && out_free;

    // Launch a fresh token into the first cell
    always_comb
    begin
        tok_w[0]      = '0;
        tok_w[0].live = start_reg;
    end

    assign item_page_w = item_reg.page_number;

    // Row of slot cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ltlb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(i)),
            .item_page (item_page_w),
            .tok_in    (tok_w[i]),
            .tok_out   (tok_w[i+1]),
            .upd       (upd)
        );
    end

    // Clamp the capacity register
    always_comb
    begin
        if (limit_reg == '0)
            cap = CAP_W'(1);
        else if (CAP_W'(limit_reg) > CAP_W'(ENTRIES))
            cap = CAP_W'(ENTRIES);
        else
            cap = CAP_W'(limit_reg);
    end

    assign full = (CAP_W'(fin_reg.count) >= cap) || !fin_reg.free_ok;

    // Decide the outcome from the finished token
    always_comb
    begin
        result        = '0;
        upd           = '0;
        upd.page      = item_reg.page_number;
        upd.frame     = item_reg.fill_frame;
        if (fin_reg.found)
        begin
            result.hit   = 1'b1;
            result.frame = fin_reg.found_frame;
            upd.en       = commit;
            upd.idx      = fin_reg.found_idx;
            upd.wr_frame = (item_reg.func == FUNC_FILL);
            upd.thr      = fin_reg.found_rank;
        end
        else if (item_reg.func == FUNC_FILL)
        begin
            upd.en       = commit;
            upd.wr_page  = 1'b1;
            upd.wr_frame = 1'b1;
            if (full)
            begin
                result.evicted      = 1'b1;
                result.evicted_page = fin_reg.old_page;
                upd.idx             = fin_reg.old_idx;
                upd.thr             = fin_reg.old_rank;
            end
            else
            begin
                upd.idx       = fin_reg.free_idx;
                upd.set_valid = 1'b1;
                upd.age_all   = 1'b1;
            end
        end
    end

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok_w[ENTRIES].live)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output item until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= in_acc;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            item_reg <= in_data;
        if (state_reg == ST_SCAN && tok_w[ENTRIES].live)
            fin_reg <= tok_w[ENTRIES];
        if (commit)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> dv/lru_tlb_tb.sv
`timescale 1ns / 1ps

module lru_tlb_tb;
    import ltlb_pkg::*;

    // Directed plan row: either a capacity write or one item
    typedef struct {
        bit                 is_cap;
        logic [LIMIT_W-1:0] cap;
        in_t                item;
        bit                 known;
        out_t               want;
    } plan_row_t;

    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 113;
    localparam int POOL_MAX        = 24;
    localparam int PEND_DEPTH      = 64;
    localparam int PLAN_MAX        = 32;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_t                in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_t               out_data;
    logic               cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;

    // Mirror of the translation store
    logic [PAGE_W-1:0]  page_tab  [ENTRIES];
    logic [FRAME_W-1:0] frame_tab [ENTRIES];
    bit                 valid_tab [ENTRIES];
    logic [RANK_W-1:0]  rank_tab  [ENTRIES];
    logic [LIMIT_W-1:0] cap_reg;

    // Ring of expected results, written by the sender, read by the checker
    out_t               pending_q [PEND_DEPTH];
    int unsigned        pend_wr = 0;
    int unsigned        pend_rd = 0;
    int unsigned        mismatches = 0;
    plan_row_t          plan [PLAN_MAX];
    int unsigned        plan_n = 0;

    lru_tlb u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // Make slot s the most recent; younger valid slots age by one, or all other valid slots if s was not valid
    function automatic void make_youngest(int s, bit was_valid);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i != s && valid_tab[i] && (!was_valid || rank_tab[i] < rank_tab[s]))
                rank_tab[i] = rank_tab[i] + RANK_W'(1);
        end
        rank_tab[s] = '0;
    endfunction

    // Translate or fill one item and return the expected response
    function automatic out_t tlb_translate(in_t it);
        out_t        res;
        int          found;
        int          free_slot;
        int          oldest;
        int unsigned count;
        int unsigned cap;
        res       = '0;
        found     = -1;
        free_slot = -1;
        oldest    = -1;
        count     = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_tab[i])
            begin
                count++;
                if (found < 0 && page_tab[i] == it.page_number)
                    found = i;
                if (oldest < 0 || rank_tab[i] > rank_tab[oldest])
                    oldest = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end

        // Hit: report the old frame, refresh on fill, promote
        if (found >= 0)
        begin
            res.hit   = 1'b1;
            res.frame = frame_tab[found];
            if (it.func == FUNC_FILL)
                frame_tab[found] = it.fill_frame;
            make_youngest(found, 1'b1);
            return res;
        end
        if (it.func == FUNC_LOOKUP)
            return res;

        // Clamp capacity into 1 .. ENTRIES
        cap = 32'(cap_reg);
        if (cap < 1)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;

        if (count >= cap || free_slot < 0)
        begin
            res.evicted      = 1'b1;
            res.evicted_page = page_tab[oldest];
            page_tab[oldest]  = it.page_number;
            frame_tab[oldest] = it.fill_frame;
            make_youngest(oldest, 1'b1);
        end
        else
        begin
            page_tab[free_slot]  = it.page_number;
            frame_tab[free_slot] = it.fill_frame;
            make_youngest(free_slot, 1'b0);
            valid_tab[free_slot] = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Present one item and hold it until accepted
    task automatic send_item(in_t it, bit known, out_t want);
        out_t predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = tlb_translate(it);
        pending_q[pend_wr % PEND_DEPTH] = known ? want : predicted;
        pend_wr++;
    endtask

    task automatic idle_sender(int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every pending result has arrived
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge clk);
    endtask

    // Write the capacity register with the block idle
    task automatic set_capacity(logic [LIMIT_W-1:0] v);
        drain_results();
        repeat (ENTRIES + 4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cap_reg = v;
    endtask

    function automatic plan_row_t row_item(logic func, logic [PAGE_W-1:0] page,
                                           logic [FRAME_W-1:0] frm);
        plan_row_t r;
        r.is_cap = 1'b0;
        r.cap    = '0;
        r.item   = '{func, page, frm};
        r.known  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic plan_row_t row_known(logic func, logic [PAGE_W-1:0] page,
                                            logic [FRAME_W-1:0] frm, out_t want);
        plan_row_t r;
        r       = row_item(func, page, frm);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t row_cap(logic [LIMIT_W-1:0] v);
        plan_row_t r;
        r        = row_item(FUNC_LOOKUP, '0, '0);
        r.is_cap = 1'b1;
        r.cap    = v;
        return r;
    endfunction

    // Append one row to the directed plan
    function automatic void add_row(plan_row_t r);
        plan[plan_n] = r;
        plan_n++;
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pend_wr == pend_rd)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                want = pending_q[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (out_data.hit !== want.hit)
                    report_mismatch("hit", out_data.hit, want.hit);
                if (out_data.frame !== want.frame)
                    report_mismatch("frame", out_data.frame, want.frame);
                if (out_data.evicted !== want.evicted)
                    report_mismatch("evicted", out_data.evicted, want.evicted);
                if (out_data.evicted_page !== want.evicted_page)
                    report_mismatch("evicted_page", out_data.evicted_page,
                                    want.evicted_page);
            end
        end
    end

    // Receiver: random stalls with calm stretches
    initial
    begin : receiver
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left = 0;
        calm_left  = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 49) == 0)
                    calm_left = $urandom_range(20, 200);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] phase_caps [RAND_PHASES];
        logic [PAGE_W-1:0]  pool [POOL_MAX];
        int unsigned        pool_n;
        int unsigned        eff;
        bit                 no_idle;
        in_t                it;

        // Store starts empty with capacity at reset value
        for (int i = 0; i < ENTRIES; i++)
        begin
            page_tab[i]  = '0;
            frame_tab[i] = '0;
            valid_tab[i] = 1'b0;
            rank_tab[i]  = '0;
        end
        cap_reg = LIMIT_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, present-page refill, capacity shrink and regrowth
        add_row(row_known(FUNC_LOOKUP, 20'h00000, 20'hFFFFF, '0));
        add_row(row_known(FUNC_FILL,   20'h00000, 20'hFFFFF, '0));
        add_row(row_known(FUNC_LOOKUP, 20'h00000, 20'h00000,
                          '{1'b1, 20'hFFFFF, 1'b0, 20'h0}));
        add_row(row_known(FUNC_FILL,   20'hFFFFF, 20'h00000, '0));
        add_row(row_known(FUNC_LOOKUP, 20'hFFFFF, 20'hFFFFF,
                          '{1'b1, 20'h00000, 1'b0, 20'h0}));
        add_row(row_known(FUNC_FILL,   20'h00000, 20'h12345,
                          '{1'b1, 20'hFFFFF, 1'b0, 20'h0}));
        add_row(row_known(FUNC_LOOKUP, 20'h00000, 20'h00000,
                          '{1'b1, 20'h12345, 1'b0, 20'h0}));
        add_row(row_known(FUNC_LOOKUP, 20'h00001, 20'h00000, '0));
        add_row(row_cap(5'd1));
        add_row(row_known(FUNC_FILL,   20'h00AAA, 20'h00555,
                          '{1'b0, 20'h0, 1'b1, 20'hFFFFF}));
        add_row(row_known(FUNC_LOOKUP, 20'hFFFFF, 20'h00000, '0));
        add_row(row_item(FUNC_FILL,    20'h00555, 20'h00AAA));
        add_row(row_cap(5'd0));
        add_row(row_item(FUNC_FILL,    20'hF0F0F, 20'h0F0F0));
        add_row(row_item(FUNC_LOOKUP,  20'h00AAA, 20'h00000));
        add_row(row_cap(5'd31));
        add_row(row_item(FUNC_FILL,    20'h00003, 20'h33333));
        add_row(row_item(FUNC_FILL,    20'h80000, 20'h7FFFF));
        add_row(row_item(FUNC_LOOKUP,  20'h00555, 20'h00000));
        add_row(row_item(FUNC_FILL,    20'h00555, 20'hFFFFF));
        add_row(row_item(FUNC_LOOKUP,  20'h80000, 20'h00000));
        add_row(row_cap(5'd16));

        for (int k = 0; k < plan_n; k++)
        begin
            if (plan[k].is_cap)
                set_capacity(plan[k].cap);
            else
            begin
                idle_sender($urandom_range(0, 1) ? pick_gap() : 0);
                send_item(plan[k].item, plan[k].known, plan[k].want);
            end
        end

        // Random phases over several capacities, extremes included
        phase_caps = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd2, 5'd31, 5'd4, 5'd16, 5'd12, 5'd0};
        phase_caps[RAND_PHASES - 1] = LIMIT_W'($urandom_range(0, 31));

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            eff = 32'(phase_caps[p]);
            if (eff < 1)
                eff = 1;
            if (eff > ENTRIES)
                eff = ENTRIES;
            pool_n = $urandom_range(eff + 1, (eff + 8 > POOL_MAX) ? POOL_MAX : eff + 8);
            for (int j = 0; j < POOL_MAX; j++)
                pool[j] = PAGE_W'($urandom_range(0, 20'hFFFFF));
            no_idle = (p % 4 == 2);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.func        = $urandom_range(0, 1) ? FUNC_FILL : FUNC_LOOKUP;
                it.page_number = ($urandom_range(0, 4) == 0)
                                 ? PAGE_W'($urandom_range(0, 20'hFFFFF))
                                 : pool[$urandom_range(0, pool_n - 1)];
                it.fill_frame  = FRAME_W'($urandom_range(0, 20'hFFFFF));

                // Hold off now and then until the pipe is empty
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                else if (!no_idle)
                    idle_sender($urandom_range(0, 1) ? pick_gap() : 0);
                send_item(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (ENTRIES * 3) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
